### rtl/kns_pkg.sv
// ---------------------------------------------------------------------------
// kns_pkg
// shared types and constants of the keypoint suppressor
// ---------------------------------------------------------------------------
package kns_pkg;

  localparam int COORD_W = 12;
  localparam int SCORE_W = 16;
  localparam int RAD_W   = 4;
  localparam int PT_W    = 2 * COORD_W + SCORE_W;
  localparam logic [RAD_W-1:0] RAD_RESET = 4'd4;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SEL_INIT,
    ST_SEL_SCAN,
    ST_SEL_EVAL,
    ST_CHK_INIT,
    ST_CHK_SCAN,
    ST_CHK_EVAL,
    ST_DR_INIT,
    ST_DR_RD,
    ST_DR_LD,
    ST_DR_OUT,
    ST_FINISH
  } kns_state_t;

  typedef struct packed {
    logic load_en;
    logic scan_clr;
    logic best_clr;
    logic scan_store;
    logic mark_used;
    logic hit_clr;
    logic scan_kept;
    logic keep_wr;
    logic drain_rd;
    logic out_load;
    logic finish;
  } kns_cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic best_vld;
    logic hit;
    logic kept_empty;
    logic out_final;
  } kns_stat_t;

endpackage

### rtl/kns_ctrl.sv
// ---------------------------------------------------------------------------
// kns_ctrl
// sequencer for load, select-max, neighbor check and drain phases
// ---------------------------------------------------------------------------
module kns_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  kns_pkg::kns_stat_t stat,
  output kns_pkg::kns_cmd_t  cmd
);
  import kns_pkg::*;

  kns_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:     if (in_tvalid && in_tlast) state_nxt = ST_SEL_INIT;
      ST_SEL_INIT: state_nxt = ST_SEL_SCAN;
      ST_SEL_SCAN: if (!stat.scan_busy) state_nxt = ST_SEL_EVAL;
      ST_SEL_EVAL: begin
        if (stat.best_vld)        state_nxt = ST_CHK_INIT;
        else if (stat.kept_empty) state_nxt = ST_FINISH;
        else                      state_nxt = ST_DR_INIT;
      end
      ST_CHK_INIT: state_nxt = ST_CHK_SCAN;
      ST_CHK_SCAN: if (!stat.scan_busy) state_nxt = ST_CHK_EVAL;
      ST_CHK_EVAL: state_nxt = ST_SEL_INIT;
      ST_DR_INIT:  state_nxt = ST_DR_RD;
      ST_DR_RD:    state_nxt = ST_DR_LD;
      ST_DR_LD:    state_nxt = ST_DR_OUT;
      ST_DR_OUT: begin
        if (out_tready) state_nxt = stat.out_final ? ST_FINISH : ST_DR_RD;
      end
      ST_FINISH:   state_nxt = ST_LOAD;
      default:     state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready   = 1'b1;
        cmd.load_en = in_tvalid;
      end
      ST_SEL_INIT: begin
        cmd.scan_clr = 1'b1;
        cmd.best_clr = 1'b1;
      end
      ST_SEL_SCAN: cmd.scan_store = 1'b1;
      ST_SEL_EVAL: cmd.mark_used = stat.best_vld;
      ST_CHK_INIT: begin
        cmd.scan_clr = 1'b1;
        cmd.hit_clr  = 1'b1;
      end
      ST_CHK_SCAN: cmd.scan_kept = 1'b1;
      ST_CHK_EVAL: cmd.keep_wr = !stat.hit;
      ST_DR_INIT:  cmd.scan_clr = 1'b1;
      ST_DR_RD:    cmd.drain_rd = 1'b1;
      ST_DR_LD:    cmd.out_load = 1'b1;
      ST_DR_OUT:   out_tvalid = 1'b1;
      ST_FINISH:   cmd.finish = 1'b1;
      default:     cmd = '0;
    endcase
  end

endmodule

### rtl/kns_datapath.sv
// ---------------------------------------------------------------------------
// kns_datapath
// point store, kept list, max search, chebyshev check and output register
// ---------------------------------------------------------------------------
module kns_datapath #(
  parameter int MAX_POINTS       = 64,
  parameter int IMAGE_HEIGHT_MAX = 4096,
  parameter int IMAGE_WIDTH_MAX  = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [kns_pkg::RAD_W-1:0] cfg_wdata,
  input  logic [kns_pkg::PT_W-1:0]  in_tdata,
  output logic [kns_pkg::PT_W-1:0]  out_tdata,
  output logic                      out_tlast,
  input  kns_pkg::kns_cmd_t          cmd,
  output kns_pkg::kns_stat_t         stat
);
  import kns_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [PT_W-1:0] store_mem [MAX_POINTS];
  logic [PT_W-1:0] kept_mem  [MAX_POINTS];

  logic [RAD_W-1:0]      rad_r;
  logic [CW-1:0]         pnt_cnt_r, kept_cnt_r, idx_r;
  logic                  rd_vld_r;
  logic [AW-1:0]         rd_idx_r;
  logic [PT_W-1:0]       store_q_r, kept_q_r;
  logic [MAX_POINTS-1:0] used_r;
  logic                  best_vld_r;
  logic [AW-1:0]         best_idx_r;
  logic [PT_W-1:0]       best_pt_r;
  logic                  hit_r;
  logic                  last_r;
  logic [PT_W-1:0]       out_data_r;
  logic                  out_final_r;

  logic                  in_range, store_wr;
  logic [CW-1:0]         lim;
  logic                  issue;
  logic [COORD_W-1:0]    qc, qr, bc, br, dc, dr;
  logic                  near;

  assign in_range = ({20'd0, in_tdata[COORD_W-1:0]} < 32'(IMAGE_WIDTH_MAX)) &&
                    ({20'd0, in_tdata[2*COORD_W-1:COORD_W]} < 32'(IMAGE_HEIGHT_MAX));
  assign store_wr = cmd.load_en && in_range && (pnt_cnt_r < CW'(MAX_POINTS));
  assign lim      = cmd.scan_kept ? kept_cnt_r : pnt_cnt_r;
  assign issue    = (cmd.scan_store || cmd.scan_kept) && (idx_r < lim);

  // chebyshev distance check of a kept point against the candidate
  assign qc   = kept_q_r[COORD_W-1:0];
  assign qr   = kept_q_r[2*COORD_W-1:COORD_W];
  assign bc   = best_pt_r[COORD_W-1:0];
  assign br   = best_pt_r[2*COORD_W-1:COORD_W];
  assign dc   = (qc >= bc) ? qc - bc : bc - qc;
  assign dr   = (qr >= br) ? qr - br : br - qr;
  assign near = (dc <= {{(COORD_W-RAD_W){1'b0}}, rad_r}) &&
                (dr <= {{(COORD_W-RAD_W){1'b0}}, rad_r});

  always_ff @(posedge clk) begin
    if (store_wr) store_mem[pnt_cnt_r[AW-1:0]] <= in_tdata;
    if (cmd.scan_store && issue) store_q_r <= store_mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.keep_wr) kept_mem[kept_cnt_r[AW-1:0]] <= best_pt_r;
    if ((cmd.scan_kept && issue) || cmd.drain_rd) kept_q_r <= kept_mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r      <= RAD_RESET;
      pnt_cnt_r  <= '0;
      kept_cnt_r <= '0;
      idx_r      <= '0;
      rd_vld_r   <= 1'b0;
      used_r     <= '0;
      best_vld_r <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      if (cfg_we) rad_r <= cfg_wdata;
      if (cmd.finish)    pnt_cnt_r <= '0;
      else if (store_wr) pnt_cnt_r <= pnt_cnt_r + 1'b1;
      if (cmd.finish)       kept_cnt_r <= '0;
      else if (cmd.keep_wr) kept_cnt_r <= kept_cnt_r + 1'b1;
      if (cmd.scan_clr)                idx_r <= '0;
      else if (issue || cmd.drain_rd) idx_r <= idx_r + 1'b1;
      rd_vld_r <= issue;
      if (cmd.finish)         used_r <= '0;
      else if (cmd.mark_used) used_r[best_idx_r] <= 1'b1;
      // strict compare keeps the earliest arrival on equal scores
      if (cmd.best_clr) best_vld_r <= 1'b0;
      else if (cmd.scan_store && rd_vld_r && !used_r[rd_idx_r] &&
               (!best_vld_r || store_q_r[PT_W-1:2*COORD_W] > best_pt_r[PT_W-1:2*COORD_W]))
        best_vld_r <= 1'b1;
      if (cmd.hit_clr) hit_r <= 1'b0;
      else if (cmd.scan_kept && rd_vld_r && near) hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r[AW-1:0];
    if (cmd.scan_store && rd_vld_r && !used_r[rd_idx_r] &&
        (!best_vld_r || store_q_r[PT_W-1:2*COORD_W] > best_pt_r[PT_W-1:2*COORD_W])) begin
      best_pt_r  <= store_q_r;
      best_idx_r <= rd_idx_r;
    end
    if (cmd.drain_rd) last_r <= ((idx_r + 1'b1) == kept_cnt_r);
    if (cmd.out_load) begin
      out_data_r  <= kept_q_r;
      out_final_r <= last_r;
    end
  end

  assign out_tdata       = out_data_r;
  assign out_tlast       = out_final_r;
  assign stat.scan_busy  = (idx_r < lim) || rd_vld_r;
  assign stat.best_vld   = best_vld_r;
  assign stat.hit        = hit_r;
  assign stat.kept_empty = (kept_cnt_r == '0);
  assign stat.out_final  = out_final_r;

  a_kept_le_pnt: assert property (@(posedge clk) disable iff (!rst_n)
    kept_cnt_r <= pnt_cnt_r) else $error("kept count exceeds point count");
  a_pnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pnt_cnt_r <= CW'(MAX_POINTS)) else $error("point count overflow");
  a_keep_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.keep_wr |-> (best_vld_r && !hit_r)) else $error("keep without clean candidate");
  a_mark_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_used |=> $countones(used_r) == $countones($past(used_r)) + 1)
    else $error("candidate picked twice");

endmodule

### rtl/keypoint_nms_suppressor.sv
// ---------------------------------------------------------------------------
// keypoint_nms_suppressor
// keypoint non-maximum suppression with a square radius, output in score order
// ---------------------------------------------------------------------------
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | in_tdata{col,row,score}, in_tlast last_point
// out_    | out | out_tvalid/out_tready| out_tdata{kept_col,kept_row,kept_score},
//         |     |                      | out_tlast final_result
// cfg_    | in  | cfg_we               | cfg_wdata suppress_radius
//
// points load at one item per cycle in the load phase; after the item marked
// last the block repeatedly scans the point store for the best unused score
// (one store read port) and checks it against the kept list (one read port);
// each survivor then drains through read, load and output states; in_tready is
// low from the last point until the block has left its finish state after the
// final survivor is taken
// reset (rst_n low, synchronous) empties the set and sets the radius to 4
// ---------------------------------------------------------------------------
module keypoint_nms_suppressor #(
  parameter int MAX_POINTS       = 64,
  parameter int IMAGE_HEIGHT_MAX = 4096,
  parameter int IMAGE_WIDTH_MAX  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,   // suppress_radius
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // col[11:0], row[23:12], score[39:24]
  input  logic        in_tlast,    // last_point
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // kept_col[11:0], kept_row[23:12], kept_score[39:24]
  output logic        out_tlast    // final_result
);
  import kns_pkg::*;

  kns_cmd_t  cmd;
  kns_stat_t stat;

  // sequencer: owns the handshakes and phase order
  kns_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // storage, search and compare
  kns_datapath #(
    .MAX_POINTS       (MAX_POINTS),
    .IMAGE_HEIGHT_MAX (IMAGE_HEIGHT_MAX),
    .IMAGE_WIDTH_MAX  (IMAGE_WIDTH_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

### bench/keypoint_nms_suppressor_tb.sv
// ---------------------------------------------------------------------------
// keypoint_nms_suppressor_tb
// feeds keypoint sets with random and directed content, predicts the kept
// points with a score-ordered square-radius suppression and compares every
// output item, final flag included, against the prediction
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module keypoint_nms_suppressor_tb;
  import kns_pkg::*;

  localparam int MAX_PTS   = 64;
  localparam int IDLE_LIM  = 200000;
  localparam int DRAIN_GAP = 40;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } point_t;

  typedef struct packed {
    logic   last;
    point_t pt;
  } in_item_t;

  typedef struct packed {
    logic   final_flag;
    point_t pt;
  } kept_item_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [RAD_W-1:0]   cfg_wdata;
  logic               in_tvalid;
  logic               in_tready;
  logic [PT_W-1:0]    in_tdata;
  logic               in_tlast;
  logic               out_tvalid;
  logic               out_tready;
  logic [PT_W-1:0]    out_tdata;
  logic               out_tlast;

  keypoint_nms_suppressor dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),   // col, row, score
    .in_tlast(in_tlast),   // last_point
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), // kept_col, kept_row, kept_score
    .out_tlast(out_tlast)  // final_result
  );

  // predictor state
  logic [RAD_W-1:0] radius_mdl;
  point_t           set_pts[$];

  in_item_t   pending_pts[$];
  kept_item_t kept_expect[$];
  int         mismatches = 0;
  int         idle_cycles;
  bit         hold_off_req;

  // stores the point and, on the set's last item, predicts the survivors
  function automatic void predict_point(in_item_t it);
    point_t ord[$];
    point_t kept[$];
    int     j;
    bit     hit;
    int     dc, dr;
    kept_item_t k;
    if (set_pts.size() < MAX_PTS) set_pts.insert(set_pts.size(), it.pt);
    if (!it.last) return;
    // stable insertion by descending score
    foreach (set_pts[i]) begin
      j = ord.size();
      while (j > 0 && ord[j-1].score < set_pts[i].score) j--;
      ord.insert(j, set_pts[i]);
    end
    foreach (ord[i]) begin
      hit = 0;
      foreach (kept[q]) begin
        dc = int'(ord[i].col) - int'(kept[q].col);
        dr = int'(ord[i].row) - int'(kept[q].row);
        if (dc < 0) dc = -dc;
        if (dr < 0) dr = -dr;
        if (dc <= int'(radius_mdl) && dr <= int'(radius_mdl)) hit = 1;
      end
      if (!hit) kept.insert(kept.size(), ord[i]);
    end
    foreach (kept[i]) begin
      k.pt = kept[i];
      k.final_flag = (i == kept.size() - 1);
      kept_expect.insert(kept_expect.size(), k);
    end
    set_pts.delete();
  endfunction

  // no gap mostly, short gaps often, a few long ones
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // ---------------- driver ----------------
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata  <= '0;
      in_tlast  <= 0;
      send_gap  <= 0;
    end else begin
      // the presented item is always the front of the queue
      if (in_tvalid && in_tready) begin
        predict_point(pending_pts.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 0;
        end else if (pending_pts.size() > 0) begin
          in_tdata  <= pending_pts[0].pt;
          in_tlast  <= pending_pts[0].last;
          in_tvalid <= 1;
          send_gap  <= gap_len();
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // ---------------- monitor and receiver ----------------
  int recv_gap;
  int hold_cnt;
  kept_item_t got;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
      recv_gap   <= 0;
      hold_cnt   <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.pt = out_tdata;
        got.final_flag = out_tlast;
        if (kept_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output item col=%0d row=%0d score=%0h last=%0b",
                     got.pt.col, got.pt.row, got.pt.score, got.final_flag);
        end else begin
          if (got !== kept_expect[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp col=%0d row=%0d score=%0h last=%0b,",
                        " got col=%0d row=%0d score=%0h last=%0b"},
                       kept_expect[0].pt.col, kept_expect[0].pt.row,
                       kept_expect[0].pt.score, kept_expect[0].final_flag,
                       got.pt.col, got.pt.row, got.pt.score, got.final_flag);
          end
          void'(kept_expect.pop_front());
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      // long hold-off: output stalls, and the block keeps its input stalled
      if (hold_off_req && hold_cnt == 0) begin
        hold_cnt   <= 3000;
        out_tready <= 0;
      end else if (hold_cnt > 0) begin
        hold_cnt   <= hold_cnt - 1;
        out_tready <= (hold_cnt == 1);
      end else if (recv_gap > 0) begin
        recv_gap   <= recv_gap - 1;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
        if (out_tvalid && out_tready) recv_gap <= gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && idle_cycles > IDLE_LIM) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic in_item_t mk(int c, int r, int s, bit l);
    in_item_t it;
    it.pt.col   = COORD_W'(c);
    it.pt.row   = COORD_W'(r);
    it.pt.score = SCORE_W'(s);
    it.last     = l;
    return it;
  endfunction

  function automatic void enqueue_pt(in_item_t it);
    pending_pts.insert(pending_pts.size(), it);
  endfunction

  // a set with random content; unless wide, coordinates near a center so
  // suppression actually fires
  task automatic queue_set(int n, bit wide);
    int cx, cy, sp;
    cx = $urandom_range(0, 4095);
    cy = $urandom_range(0, 4095);
    sp = wide ? 4095 : $urandom_range(2, 40);
    for (int i = 0; i < n; i++) begin
      int c, r, s;
      c = wide ? $urandom_range(0, 4095) : (cx + $urandom_range(0, sp)) % 4096;
      r = wide ? $urandom_range(0, 4095) : (cy + $urandom_range(0, sp)) % 4096;
      s = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) * 16384
                                       : $urandom_range(0, 65535);
      enqueue_pt(mk(c, r, s, i == n - 1));
    end
  endtask

  task automatic wait_idle();
    while (pending_pts.size() > 0 || in_tvalid || kept_expect.size() > 0)
      @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_radius(logic [RAD_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 0;
    radius_mdl = v;
  endtask

  int sent;
  int n;
  initial begin
    rst_n = 0; cfg_we = 0; cfg_wdata = '0;
    hold_off_req = 0;
    radius_mdl = RAD_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // directed, reset radius: extremes, ties, duplicates, single
    enqueue_pt(mk(0, 0, 0, 1));                 // single point, zero score
    enqueue_pt(mk(4095, 4095, 65535, 1));       // single at far corner
    enqueue_pt(mk(100, 100, 500, 0));           // ties keep arrival order
    enqueue_pt(mk(102, 98, 500, 0));
    enqueue_pt(mk(200, 200, 500, 0));
    enqueue_pt(mk(104, 104, 600, 1));
    enqueue_pt(mk(7, 9, 1000, 0));              // duplicate coordinates
    enqueue_pt(mk(7, 9, 2000, 0));
    enqueue_pt(mk(7, 9, 2000, 0));
    enqueue_pt(mk(11, 13, 1500, 0));            // exactly at radius
    enqueue_pt(mk(12, 9, 1400, 1));             // just outside
    enqueue_pt(mk(4095, 0, 32768, 0));
    enqueue_pt(mk(0, 4095, 32769, 1));
    wait_idle();

    // store full: 70 points, extras ignored, last flag still closes the set
    write_radius(4'd0);
    for (int i = 0; i < 70; i++)
      enqueue_pt(mk((i * 37) % 4096, (i * 53) % 4096,
                    $urandom_range(0, 65535), i == 69));
    wait_idle();

    write_radius(4'd15);
    queue_set(20, 0);
    queue_set(1, 0);
    wait_idle();

    // random sets over several radii, with one long receiver hold-off
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_radius(ph == 0 ? 4'd15 : ph == 1 ? 4'd0 : RAD_W'($urandom_range(0, 15)));
      while (sent < (ph + 1) * 50) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 12);
        queue_set(n, $urandom_range(0, 3) == 0);
        sent += n;
      end
      if (ph == 2) begin
        hold_off_req <= 1;
        @(posedge clk);
        hold_off_req <= 0;
      end
      wait_idle();
    end

    if (mismatches == 0 && kept_expect.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
